// ===== hw/rtl/bfei_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bfei_pkg;

  localparam int OFFSET_W   = 11;
  localparam int COUNT_W    = 8;
  localparam int VALUE_W    = 64;
  localparam int POS_W      = 12;
  localparam int BYTE_IDX_W = POS_W - 3;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // one byte of the field on its way from the store read port to the datapath
  typedef struct packed {
    logic                  step;
    logic                  wr;
    logic [BYTE_IDX_W-1:0] byte_idx;
    logic [2:0]            lo;
    logic [2:0]            hi;
  } stage_t;

  // field bits lo..hi of a byte, counted msb first
  function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [2:0] hi);
    span_mask = (8'hff >> lo) & (8'hff << (3'd7 - hi));
  endfunction

  function automatic logic [3:0] span_len(input logic [2:0] lo, input logic [2:0] hi);
    span_len = {1'b0, hi} - {1'b0, lo} + 4'd1;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bfei_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bfei_req_if import bfei_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [OFFSET_W-1:0] bit_offset;
  logic [COUNT_W-1:0]  bit_count;
  logic [VALUE_W-1:0]  write_value;

  modport source (output valid, cmd, bit_offset, bit_count, write_value, input ready);
  modport sink   (input valid, cmd, bit_offset, bit_count, write_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bfei_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bfei_rsp_if import bfei_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] read_value;
  logic               length_clamped;
  logic               out_of_range;

  modport source (output valid, read_value, length_clamped, out_of_range, input ready);
  modport sink   (input valid, read_value, length_clamped, out_of_range, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bfei_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfei_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bfei_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfei_ctrl import bfei_pkg::*; #(
  parameter int STORE_BYTES    = 256,
  parameter int MAX_FIELD_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_cmd,
  input  wire logic [OFFSET_W-1:0]   in_offset,
  input  wire logic [COUNT_W-1:0]    in_count,
  input  wire logic                  out_free,
  output logic                       fin,
  output logic                       clamped,
  output logic                       oor,
  output logic [BYTE_IDX_W-1:0]      rd_idx,
  output stage_t                     stage
);

  localparam int          CW         = $clog2(MAX_FIELD_BITS + 1);
  localparam logic [31:0] STORE_BITS = 32'(STORE_BYTES * 8);

  state_t                state, state_next;
  logic                  wr;
  logic [OFFSET_W-1:0]   first_pos;
  logic [POS_W-1:0]      last_pos;
  logic [BYTE_IDX_W-1:0] cur;

  logic                  accept;
  logic                  issue;
  logic                  count_big;
  logic [CW-1:0]         count_sat;
  logic [POS_W-1:0]      end_pos;
  logic [POS_W-1:0]      last_pos_c;
  logic                  zero_len;
  logic                  range_bad;
  logic [BYTE_IDX_W-1:0] first_byte;
  logic [BYTE_IDX_W-1:0] last_byte;
  logic [BYTE_IDX_W-1:0] stop_byte;
  logic [2:0]            lo_c;
  logic [2:0]            hi_c;

  // request decode at accept
  always_comb begin
    count_big  = in_count > COUNT_W'(MAX_FIELD_BITS);
    count_sat  = count_big ? CW'(MAX_FIELD_BITS) : in_count[CW-1:0];
    end_pos    = POS_W'(in_offset) + POS_W'(count_sat);
    last_pos_c = end_pos - POS_W'(1);
    zero_len   = count_sat == '0;
    range_bad  = 32'(end_pos) > STORE_BITS;
  end

  // byte walk: reads go front to back, writes back to front
  always_comb begin
    first_byte = {1'b0, first_pos[OFFSET_W-1:3]};
    last_byte  = last_pos[POS_W-1:3];
    stop_byte  = wr ? first_byte : last_byte;
    lo_c       = (cur == first_byte) ? first_pos[2:0] : 3'd0;
    hi_c       = (cur == last_byte) ? last_pos[2:0] : 3'd7;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (zero_len || range_bad) ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (cur == stop_byte) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state == ST_IDLE;
    issue    = state == ST_RUN;
    fin      = (state == ST_FIN) && out_free;
    accept   = in_valid && in_ready;
    rd_idx   = cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      stage.step <= 1'b0;
    end else begin
      state      <= state_next;
      stage.step <= issue;
    end
    if (accept) begin
      wr        <= in_cmd == CMD_WRITE;
      first_pos <= in_offset;
      last_pos  <= last_pos_c;
      clamped   <= count_big;
      oor       <= range_bad && !zero_len;
      cur       <= (in_cmd == CMD_WRITE) ? last_pos_c[POS_W-1:3]
                                         : {1'b0, in_offset[OFFSET_W-1:3]};
    end else if (issue) begin
      cur <= wr ? cur - BYTE_IDX_W'(1) : cur + BYTE_IDX_W'(1);
    end
    stage.wr       <= wr;
    stage.byte_idx <= cur;
    stage.lo       <= lo_c;
    stage.hi       <= hi_c;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bfei_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfei_dp import bfei_pkg::*; #(
  parameter int MAX_FIELD_BITS = 64
) (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic [VALUE_W-1:0] write_value,
  input  wire stage_t             stage,
  input  wire logic [7:0]         rdata,
  output logic                    we,
  output logic [7:0]              wdata,
  output logic [VALUE_W-1:0]      read_value
);

  localparam int W = MAX_FIELD_BITS;

  logic [W-1:0] acc;
  logic [W-1:0] wsh;
  logic [W-1:0] acc_next;
  logic [W-1:0] wsh_next;
  logic [7:0]   mask;
  logic [3:0]   len;
  logic [2:0]   sh;
  logic [7:0]   bits;

  always_comb begin
    mask     = span_mask(stage.lo, stage.hi);
    len      = span_len(stage.lo, stage.hi);
    sh       = 3'd7 - stage.hi;
    bits     = (rdata & mask) >> sh;
    wdata    = (rdata & ~mask) | ((wsh[7:0] << sh) & mask);
    acc_next = (acc << len) | W'(bits);
    wsh_next = wsh >> len;
    we       = stage.step && stage.wr;
    read_value = VALUE_W'(acc);
  end

  // read bits shift in at the bottom, write bits leave from the bottom
  always_ff @(posedge clk) begin
    if (load) begin
      acc <= '0;
      wsh <= write_value[W-1:0];
    end else if (stage.step) begin
      if (stage.wr) begin
        wsh <= wsh_next;
      end else begin
        acc <= acc_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bit_field_extract_insert.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  modport  beat
// req      sink     cmd, bit_offset, bit_count, write_value
// rsp      source   read_value, length_clamped, out_of_range
//
// a field touching n store bytes (1 to 9) is walked in RUN, passes DRAIN, then waits in FIN for the output
// a zero-length or out-of-range request goes from IDLE straight to FIN and touches no store byte
// the block returns to IDLE as its result is registered; it takes no request while one is in flight
// the store port reads one byte per cycle, writes merge one byte per cycle behind it
// the store is not cleared by reset
// a result waits in the output register while the next request is accepted

module bit_field_extract_insert import bfei_pkg::*; #(
  parameter int STORE_BYTES    = 256,
  parameter int MAX_FIELD_BITS = 64
) (
  input wire logic   clk,
  input wire logic   rst,
  bfei_req_if.sink   req,
  bfei_rsp_if.source rsp
);

  localparam int AW = $clog2(STORE_BYTES);

  stage_t                stage;
  logic                  in_ready;
  logic                  out_free;
  logic                  fin;
  logic                  clamped;
  logic                  oor;
  logic [BYTE_IDX_W-1:0] rd_idx;
  logic                  ram_we;
  logic [7:0]            ram_wdata;
  logic [7:0]            ram_rdata;
  logic [VALUE_W-1:0]    acc_value;

  logic                  out_valid;
  logic [VALUE_W-1:0]    out_value;
  logic                  out_clamped;
  logic                  out_oor;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = in_ready;

  bfei_ctrl #(
    .STORE_BYTES    (STORE_BYTES),
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .in_cmd    (req.cmd),
    .in_offset (req.bit_offset),
    .in_count  (req.bit_count),
    .out_free  (out_free),
    .fin       (fin),
    .clamped   (clamped),
    .oor       (oor),
    .rd_idx    (rd_idx),
    .stage     (stage)
  );

  bfei_dp #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_dp (
    .clk         (clk),
    .load        (req.valid && in_ready),
    .write_value (req.write_value),
    .stage       (stage),
    .rdata       (ram_rdata),
    .we          (ram_we),
    .wdata       (ram_wdata),
    .read_value  (acc_value)
  );

  bfei_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(stage.byte_idx)),
    .wdata (ram_wdata),
    .raddr (AW'(rd_idx)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (fin) begin
      out_value   <= acc_value;
      out_clamped <= clamped;
      out_oor     <= oor;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.read_value     = out_value;
  assign rsp.length_clamped = out_clamped;
  assign rsp.out_of_range   = out_oor;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while a request is in flight");

  a_no_write_at_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |-> !ram_we)
    else $error("store written while idle");

  a_write_span_ordered: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> stage.lo <= stage.hi)
    else $error("store write with an empty bit span");

  a_oor_reads_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_oor |-> out_value == '0)
    else $error("out-of-range result carries data");

endmodule

`default_nettype wire

// ===== test/bit_field_extract_insert_test.sv =====
`timescale 1ns / 1ps

module bit_field_extract_insert_test import bfei_pkg::*; ();

  localparam int STORE_BITS  = 256 * 8;
  localparam int MAX_BITS    = 64;
  localparam int RANDOM_BEATS = 2000;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int SETTLE      = 20;

  typedef struct packed {
    logic                cmd;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  value;
  } field_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               clamped;
    logic               oor;
  } field_rsp_t;

  typedef struct packed {
    field_req_t beat;
    logic       known;
    field_rsp_t result;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [0:23] = '{
    '{'{CMD_WRITE, 11'd0,    8'd64,  64'h0123456789abcdef}, 1'b1, '{64'h0, 1'b0, 1'b0}},
    '{'{CMD_READ,  11'd0,    8'd64,  64'h0},                1'b1,
      '{64'h0123456789abcdef, 1'b0, 1'b0}},
    '{'{CMD_READ,  11'd4,    8'd8,   64'h0},                1'b1, '{64'h12, 1'b0, 1'b0}},
    '{'{CMD_READ,  11'd0,    8'd0,   64'h0},                1'b1, '{64'h0, 1'b0, 1'b0}},
    '{'{CMD_WRITE, 11'd0,    8'd0,   64'hffffffffffffffff}, 1'b1, '{64'h0, 1'b0, 1'b0}},
    '{'{CMD_READ,  11'd0,    8'd200, 64'hdeadbeefdeadbeef}, 1'b1,
      '{64'h0123456789abcdef, 1'b1, 1'b0}},
    '{'{CMD_WRITE, 11'd1984, 8'd64,  64'hffffffffffffffff}, 1'b1, '{64'h0, 1'b0, 1'b0}},
    '{'{CMD_READ,  11'd1984, 8'd255, 64'h0},                1'b1,
      '{64'hffffffffffffffff, 1'b1, 1'b0}},
    '{'{CMD_READ,  11'd2047, 8'd1,   64'h0},                1'b1, '{64'h1, 1'b0, 1'b0}},
    '{'{CMD_READ,  11'd2047, 8'd2,   64'h0},                1'b1, '{64'h0, 1'b0, 1'b1}},
    '{'{CMD_WRITE, 11'd1985, 8'd64,  64'h0},                1'b1, '{64'h0, 1'b0, 1'b1}},
    '{'{CMD_WRITE, 11'd2047, 8'd255, 64'h0},                1'b1, '{64'h0, 1'b1, 1'b1}},
    '{'{CMD_READ,  11'd1984, 8'd64,  64'h0},                1'b1,
      '{64'hffffffffffffffff, 1'b0, 1'b0}},
    '{'{CMD_WRITE, 11'd2047, 8'd1,   64'h0},                1'b1, '{64'h0, 1'b0, 1'b0}},
    '{'{CMD_READ,  11'd1984, 8'd64,  64'h0},                1'b1,
      '{64'hfffffffffffffffe, 1'b0, 1'b0}},
    '{'{CMD_WRITE, 11'd3,    8'd64,  64'hfedcba9876543210}, 1'b1, '{64'h0, 1'b0, 1'b0}},
    '{'{CMD_READ,  11'd3,    8'd64,  64'h0},                1'b1,
      '{64'hfedcba9876543210, 1'b0, 1'b0}},
    '{'{CMD_READ,  11'd0,    8'd8,   64'h0},                1'b0, '{64'h0, 1'b0, 1'b0}},
    '{'{CMD_WRITE, 11'd10,   8'd3,   64'hffffffffffffffff}, 1'b1, '{64'h0, 1'b0, 1'b0}},
    '{'{CMD_READ,  11'd8,    8'd8,   64'h0},                1'b0, '{64'h0, 1'b0, 1'b0}},
    '{'{CMD_WRITE, 11'd2000, 8'd65,  64'h0f0f0f0f0f0f0f0f}, 1'b1, '{64'h0, 1'b1, 1'b1}},
    '{'{CMD_WRITE, 11'd1024, 8'd64,  64'ha5a5a5a5a5a5a5a5}, 1'b1, '{64'h0, 1'b0, 1'b0}},
    '{'{CMD_READ,  11'd1027, 8'd17,  64'h5a5a5a5a5a5a5a5a}, 1'b0, '{64'h0, 1'b0, 1'b0}},
    '{'{CMD_READ,  11'd1024, 8'd128, 64'h0},                1'b1,
      '{64'ha5a5a5a5a5a5a5a5, 1'b1, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst;
  bit   gaps_on = 1'b1;
  int   cycles = 0;
  int   errors = 0;
  int   n_reads = 0;
  int   n_writes = 0;
  int   n_clamped = 0;
  int   n_oor = 0;
  int   n_checked = 0;

  bit         store_bits [STORE_BITS];
  field_rsp_t pending_fields [$];

  bfei_req_if req ();
  bfei_rsp_if rsp ();

  bit_field_extract_insert dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_fields.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic field_rsp_t predict_field(input field_req_t r);
    field_rsp_t res;
    int len;
    int pos;
    res = '0;
    len = int'(r.count);
    pos = int'(r.offset);
    if (len > MAX_BITS) begin
      len = MAX_BITS;
      res.clamped = 1'b1;
    end
    if (len != 0) begin
      if (pos + len > STORE_BITS) begin
        res.oor = 1'b1;
      end else if (r.cmd == CMD_WRITE) begin
        for (int k = 0; k < len; k++) store_bits[pos + k] = r.value[len - 1 - k];
      end else begin
        for (int k = 0; k < len; k++) res.value = {res.value[VALUE_W-2:0], store_bits[pos + k]};
      end
    end
    return res;
  endfunction

  function automatic field_req_t random_field();
    field_req_t r;
    int pick;
    r.cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
    r.value = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 5) r.count = '0;
    else if (pick < 15) r.count = COUNT_W'($urandom_range(255, 65));
    else if (pick < 30) r.count = COUNT_W'(MAX_BITS);
    else r.count = COUNT_W'($urandom_range(63, 1));
    if ($urandom_range(99) < 15) r.offset = OFFSET_W'(STORE_BITS - 1 - $urandom_range(70));
    else r.offset = OFFSET_W'($urandom_range(STORE_BITS - 1));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    errors++;
    if (errors <= 40) $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
  endtask

  task automatic send_field(input field_req_t r, input logic known, input field_rsp_t typed);
    field_rsp_t predicted;
    if (gaps_on) begin
      while ($urandom_range(99) < 8) begin
        req.valid = 1'b0;
        @(negedge clk);
      end
    end
    req.valid = 1'b1;
    req.cmd = r.cmd;
    req.bit_offset = r.offset;
    req.bit_count = r.count;
    req.write_value = r.value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predicted = predict_field(r);
    pending_fields.push_back(known ? typed : predicted);
    if (r.cmd == CMD_WRITE) n_writes++;
    else n_reads++;
    n_clamped += int'(predicted.clamped);
    n_oor += int'(predicted.oor);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    rsp.ready <= !gaps_on || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    field_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_fields.size() == 0) begin
        report_mismatch("unexpected beat", rsp.read_value, '0);
      end else begin
        want = pending_fields.pop_front();
        if (rsp.read_value !== want.value) report_mismatch("read_value", rsp.read_value, want.value);
        if (rsp.length_clamped !== want.clamped)
          report_mismatch("length_clamped", VALUE_W'(rsp.length_clamped), VALUE_W'(want.clamped));
        if (rsp.out_of_range !== want.oor)
          report_mismatch("out_of_range", VALUE_W'(rsp.out_of_range), VALUE_W'(want.oor));
        n_checked++;
      end
    end
  end

  initial begin
    field_req_t r;
    rst = 1'b1;
    req.valid = 1'b0;
    req.cmd = CMD_READ;
    req.bit_offset = '0;
    req.bit_count = '0;
    req.write_value = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    foreach (DIR_ROWS[i]) send_field(DIR_ROWS[i].beat, DIR_ROWS[i].known, DIR_ROWS[i].result);

    // fill the whole store so every later read lands on written bytes
    for (int i = 0; i < STORE_BITS / MAX_BITS; i++) begin
      r.cmd = CMD_WRITE;
      r.offset = OFFSET_W'(i * MAX_BITS);
      r.count = COUNT_W'(MAX_BITS);
      r.value = {$urandom, $urandom};
      send_field(r, 1'b0, '0);
    end

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      gaps_on = (i < 800) || (i >= 1200);
      send_field(random_field(), 1'b0, '0);
    end
    gaps_on = 1'b1;
    req.valid = 1'b0;

    while (pending_fields.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d reads and %0d writes, %0d saturated lengths, %0d past the store end",
             n_reads, n_writes, n_clamped, n_oor);
    $display("%0d results checked in %0d cycles, %0d mismatches", n_checked, cycles, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
